// ===== sv/cpm_pkg.sv =====
package cpm_pkg;

    // Default sizes of the callsign store and of the position counter.
    localparam int CPM_MAX_CALL_LEN = 16;
    localparam int CPM_MAX_POSITION = 32;

    // Pattern characters with a special meaning.
    localparam logic [7:0] CH_DIGIT   = 8'h23;  // '#'
    localparam logic [7:0] CH_LETTER  = 8'h40;  // '@'
    localparam logic [7:0] CH_ANY     = 8'h3F;  // '?'
    localparam logic [7:0] CH_END     = 8'h2E;  // '.'
    localparam logic [7:0] CH_BR_OPEN = 8'h5B;  // '['
    localparam logic [7:0] CH_BR_CLOSE = 8'h5D; // ']'
    localparam logic [7:0] CH_RANGE   = 8'h2D;  // '-'
    localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE    = 8'h39;  // '9'
    localparam logic [7:0] CH_UPPER_A = 8'h41;  // 'A'
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;  // 'Z'

    // Operation codes of an input beat.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_MATCH = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] character;
        logic       last;
        logic       last_pattern;
    } cpm_in_t;

    typedef struct packed {
        logic pattern_match;
        logic any_match;
        logic set_done;
    } cpm_out_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
    endfunction

endpackage

// ===== sv/cpm_call_store.sv =====
module cpm_call_store import cpm_pkg::*; #(
    parameter int MAX_CALL_LEN = CPM_MAX_CALL_LEN,
    parameter int MAX_POSITION = CPM_MAX_POSITION
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  load_en,
    input  logic [7:0]                            load_char,
    input  logic                                  load_last,
    input  logic [$clog2(MAX_POSITION + 1)-1:0]   rd_pos,
    output logic [$clog2(MAX_CALL_LEN + 1)-1:0]   call_len,
    output logic [7:0]                            cur_char
);

    localparam int LEN_W = $clog2(MAX_CALL_LEN + 1);
    localparam int POS_W = $clog2(MAX_POSITION + 1);
    localparam int IDX_W = $clog2(MAX_CALL_LEN);
    localparam int AW    = (POS_W > IDX_W) ? POS_W : IDX_W;

    logic [7:0]       mem [MAX_CALL_LEN];
    logic [LEN_W-1:0] len_reg, len_next;
    logic             closed_reg, closed_next;
    logic [7:0]       rd_data_reg;
    logic [LEN_W-1:0] base_len;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [AW-1:0]    rd_wide;
    logic [IDX_W-1:0] rd_idx;

    // A load after a closed callsign starts a new one; extra characters are dropped.
    always_comb begin
        base_len    = closed_reg ? '0 : len_reg;
        wr_en       = load_en && (base_len < LEN_W'(MAX_CALL_LEN));
        wr_idx      = base_len[IDX_W-1:0];
        len_next    = len_reg;
        closed_next = closed_reg;
        if (load_en) begin
            len_next    = wr_en ? base_len + 1'b1 : base_len;
            closed_next = load_last;
        end
    end

    // Read address is the position the matcher holds next cycle.
    assign rd_wide = AW'(rd_pos);
    assign rd_idx  = rd_wide[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg    <= '0;
            closed_reg <= 1'b0;
        end else begin
            len_reg    <= len_next;
            closed_reg <= closed_next;
        end
    end

    // Store array with a registered read; a write to the read address is forwarded.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= load_char;
        end
        if (wr_en && (wr_idx == rd_idx)) begin
            rd_data_reg <= load_char;
        end else begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign call_len = len_reg;
    assign cur_char = rd_data_reg;

endmodule

// ===== sv/callsign_pattern_matcher_top.sv =====
// A pattern beat with last gives its result beat on m_*, registered, in the cycle after acceptance.
// Throughput: one input beat per cycle; s_ready drops only while a result beat is stalled.
// Each beat is one pass of compare logic against the callsign character that the
// store has already read out, registered, for the current match position.
// Reset (aresetn, synchronous, active low) clears length, position, flags and output valid;
// callsign store contents are not cleared.
module callsign_pattern_matcher_top import cpm_pkg::*; #(
    parameter int MAX_CALL_LEN = CPM_MAX_CALL_LEN,
    parameter int MAX_POSITION = CPM_MAX_POSITION
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  cpm_in_t  s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output cpm_out_t m_payload
);

    localparam int LEN_W = $clog2(MAX_CALL_LEN + 1);
    localparam int POS_W = $clog2(MAX_POSITION + 1);
    localparam int CW    = (POS_W > LEN_W) ? POS_W : LEN_W;

    logic [POS_W-1:0] pos_reg, pos_next, pos_adv;
    logic             ok_reg, ok_next;
    logic             inb_reg, inb_next;
    logic             rp_reg, rp_next;
    logic [7:0]       rs_reg, rs_next;
    logic             bh_reg, bh_next;
    logic             any_reg, any_next;
    logic             m_valid_reg, m_valid_next;
    cpm_out_t         m_payload_reg, res_next;
    logic             res_valid;
    logic             accept;
    logic             load_en;
    logic [LEN_W-1:0] call_len;
    logic [7:0]       cc;
    logic             h;
    logic [7:0]       c;
    logic             bh_close;
    logic             ok_final;
    logic             any_final;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign load_en = accept && (s_payload.operation == OP_LOAD);
    assign c       = s_payload.character;

    cpm_call_store #(
        .MAX_CALL_LEN(MAX_CALL_LEN),
        .MAX_POSITION(MAX_POSITION)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_en  (load_en),
        .load_char(c),
        .load_last(s_payload.last),
        .rd_pos   (pos_next),
        .call_len (call_len),
        .cur_char (cc)
    );

    // Callsign character present at the current position; saturating advance.
    assign h       = CW'(pos_reg) < CW'(call_len);
    assign pos_adv = (pos_reg < POS_W'(MAX_POSITION)) ? pos_reg + 1'b1 : pos_reg;

    // Next pattern state and result for one beat.
    always_comb begin
        pos_next  = pos_reg;
        ok_next   = ok_reg;
        inb_next  = inb_reg;
        rp_next   = rp_reg;
        rs_next   = rs_reg;
        bh_next   = bh_reg;
        any_next  = any_reg;
        res_valid = 1'b0;
        res_next  = '0;
        bh_close  = 1'b0;
        ok_final  = 1'b0;
        any_final = 1'b0;

        if (accept) begin
            if (s_payload.operation == OP_LOAD) begin
                // A load aborts any pattern in progress and the set.
                pos_next = '0;
                ok_next  = 1'b1;
                inb_next = 1'b0;
                rp_next  = 1'b0;
                rs_next  = '0;
                bh_next  = 1'b0;
                any_next = 1'b0;
            end else begin
                if (inb_reg) begin
                    case (c)
                        CH_RANGE:    rp_next = 1'b1;
                        CH_BR_CLOSE: begin
                            bh_close = bh_reg || !h;
                            bh_next  = bh_close;
                            ok_next  = ok_reg && bh_close;
                            inb_next = 1'b0;
                            rp_next  = 1'b0;
                            pos_next = pos_adv;
                        end
                        CH_DIGIT:    bh_next = bh_reg || (h && is_digit(cc));
                        CH_LETTER:   bh_next = bh_reg || (h && is_letter(cc));
                        CH_ANY:      bh_next = 1'b1;
                        CH_END:      bh_next = bh_reg || !h;
                        default: begin
                            if (rp_reg) begin
                                bh_next = bh_reg || (h && (cc >= rs_reg) && (cc <= c));
                            end else begin
                                rs_next = c;
                                bh_next = bh_reg || (h && (cc == c));
                            end
                            rp_next = 1'b0;
                        end
                    endcase
                end else begin
                    case (c)
                        CH_DIGIT: begin
                            ok_next  = ok_reg && h && is_digit(cc);
                            pos_next = pos_adv;
                        end
                        CH_LETTER: begin
                            ok_next  = ok_reg && h && is_letter(cc);
                            pos_next = pos_adv;
                        end
                        CH_ANY:   pos_next = pos_adv;
                        CH_END: begin
                            ok_next  = ok_reg && !h;
                            pos_next = pos_adv;
                        end
                        CH_BR_OPEN: begin
                            inb_next = 1'b1;
                            rp_next  = 1'b0;
                            rs_next  = '0;
                            bh_next  = 1'b0;
                        end
                        default: begin
                            ok_next  = ok_reg && h && (cc == c);
                            pos_next = pos_adv;
                        end
                    endcase
                end

                // End of pattern: close an open bracket, report, start over.
                if (s_payload.last) begin
                    ok_final  = inb_next ? (ok_next && (bh_next || !h)) : ok_next;
                    any_final = any_reg || ok_final;
                    res_valid = 1'b1;
                    res_next.pattern_match = ok_final;
                    res_next.any_match     = any_final;
                    res_next.set_done      = s_payload.last_pattern;
                    pos_next = '0;
                    ok_next  = 1'b1;
                    inb_next = 1'b0;
                    rp_next  = 1'b0;
                    rs_next  = '0;
                    bh_next  = 1'b0;
                    any_next = s_payload.last_pattern ? 1'b0 : any_final;
                end
            end
        end
    end

    // Output register valid: loaded by a result, freed when taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            ok_reg      <= 1'b1;
            inb_reg     <= 1'b0;
            rp_reg      <= 1'b0;
            rs_reg      <= '0;
            bh_reg      <= 1'b0;
            any_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            ok_reg      <= ok_next;
            inb_reg     <= inb_next;
            rp_reg      <= rp_next;
            rs_reg      <= rs_next;
            bh_reg      <= bh_next;
            any_reg     <= any_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload holds until replaced by the next result.
    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_payload_reg <= res_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef ASSERT_OFF
    // A stalled result beat blocks the input side.
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input accepted while result beat stalled");

    // A load beat leaves no pattern in progress and an empty set.
    a_load_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        load_en |=> (pos_reg == '0 && !inb_reg && !rp_reg && !any_reg && ok_reg))
        else $error("load beat did not clear pattern state");

    // The last pattern of a set clears the running OR.
    a_set_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && s_payload.last_pattern) |=> (!any_reg && m_payload_reg.set_done))
        else $error("set end did not clear running match");

    // A matching pattern always shows up in the running OR.
    a_any_covers: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (!m_payload_reg.pattern_match || m_payload_reg.any_match))
        else $error("pattern match missing from any_match");

    // The match position never passes its limit.
    a_pos_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(MAX_POSITION))
        else $error("match position past limit");
`endif

endmodule
